// File: sv/qamhd_pkg.sv
// qamhd_pkg: shared widths, mode and register codes, gray tables and the
// per-symbol code struct for the qam hard demapper. No dependencies.
`default_nettype none

package qamhd_pkg;

  // sample and register widths
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 15;
  localparam int MODE_W   = 3;
  localparam int ADDR_W   = 8;
  localparam int CODE_W   = 8;
  localparam int NBITS_W  = 4;
  localparam int IDX_W    = 4;
  localparam int ACC_W    = 15;
  localparam int CNT_W    = 3;

  // widest threshold is 7 * step, kept signed one bit wider
  localparam int MULT_W   = STEP_W + 3;
  localparam int THR_W    = MULT_W + 1;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_BPSK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QPSK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QAM16  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QAM64  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QAM256 = 3'd4;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] CFG_MODE        = 8'd0;
  localparam logic [ADDR_W-1:0] CFG_STEP_QAM16  = 8'd1;
  localparam logic [ADDR_W-1:0] CFG_STEP_QAM64  = 8'd2;
  localparam logic [ADDR_W-1:0] CFG_STEP_QAM256 = 8'd3;

  // register reset values
  localparam logic [MODE_W-1:0] MODE_RST        = MODE_BPSK;
  localparam logic [STEP_W-1:0] STEP_QAM16_RST  = 15'd5181;
  localparam logic [STEP_W-1:0] STEP_QAM64_RST  = 15'd2528;
  localparam logic [STEP_W-1:0] STEP_QAM256_RST = 15'd1257;

  // bits of one symbol, low bits first
  typedef struct packed {
    logic                valid;
    logic [NBITS_W-1:0]  nbits;
    logic [CODE_W-1:0]   code;
  } sym_code_t;

  // gray map for 4 levels per axis
  function automatic logic [1:0] gray16(input logic [1:0] idx);
    logic [1:0] g;
    case (idx)
      2'd0:    g = 2'b00;
      2'd1:    g = 2'b01;
      2'd2:    g = 2'b11;
      default: g = 2'b10;
    endcase
    return g;
  endfunction

  // gray map for 8 levels per axis
  function automatic logic [2:0] gray64(input logic [2:0] idx);
    logic [2:0] g;
    case (idx)
      3'd0:    g = 3'b000;
      3'd1:    g = 3'b001;
      3'd2:    g = 3'b011;
      3'd3:    g = 3'b010;
      3'd4:    g = 3'b110;
      3'd5:    g = 3'b111;
      3'd6:    g = 3'b101;
      default: g = 3'b100;
    endcase
    return g;
  endfunction

  // gray map for 16 levels per axis
  function automatic logic [3:0] gray256(input logic [3:0] idx);
    logic [3:0] g;
    case (idx)
      4'd0:    g = 4'h1;
      4'd1:    g = 4'h5;
      4'd2:    g = 4'h7;
      4'd3:    g = 4'h3;
      4'd4:    g = 4'h2;
      4'd5:    g = 4'h6;
      4'd6:    g = 4'h4;
      4'd7:    g = 4'h0;
      4'd8:    g = 4'h8;
      4'd9:    g = 4'hC;
      4'd10:   g = 4'hE;
      4'd11:   g = 4'hA;
      4'd12:   g = 4'hB;
      4'd13:   g = 4'hF;
      4'd14:   g = 4'hD;
      default: g = 4'h9;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: sv/qamhd_slicer.sv
// qamhd_slicer: slices one registered symbol into its gray-coded bits.
// Depends on qamhd_pkg.
`default_nettype none

module qamhd_slicer
  import qamhd_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] i_sample,
  input  wire logic signed [SAMPLE_W-1:0] q_sample,
  input  wire logic        [MODE_W-1:0]   mode,
  input  wire logic        [STEP_W-1:0]   step_qam16,
  input  wire logic        [STEP_W-1:0]   step_qam64,
  input  wire logic        [STEP_W-1:0]   step_qam256,
  output sym_code_t                       sym
);

  // count thresholds k*step, |k| <= top, that x is at or above
  function automatic logic [IDX_W-1:0] level_index(
    input logic signed [SAMPLE_W-1:0] x,
    input logic        [STEP_W-1:0]   step,
    input logic        [2:0]          top
  );
    logic signed [THR_W-1:0] xs;
    logic        [MULT_W-1:0] prod;
    logic signed [THR_W-1:0] thr_pos;
    logic signed [THR_W-1:0] thr_neg;
    logic        [IDX_W-1:0] idx;
    xs  = THR_W'(x);
    idx = IDX_W'(xs >= 0);
    for (int k = 1; k <= 7; k++) begin
      prod    = MULT_W'(step) * MULT_W'(k);
      thr_pos = $signed({1'b0, prod});
      thr_neg = -thr_pos;
      if (3'(k) <= top) begin
        idx = idx + IDX_W'(xs >= thr_pos) + IDX_W'(xs >= thr_neg);
      end
    end
    return idx;
  endfunction

  logic [STEP_W-1:0] step_sel;
  logic [2:0]        top_sel;
  logic [IDX_W-1:0]  idx_i;
  logic [IDX_W-1:0]  idx_q;
  logic              pos_i;
  logic              pos_q;

  // spacing and outermost threshold for the active mode
  always_comb begin
    unique case (mode)
      MODE_QAM16: begin
        step_sel = step_qam16;
        top_sel  = 3'd1;
      end
      MODE_QAM64: begin
        step_sel = step_qam64;
        top_sel  = 3'd3;
      end
      default: begin
        step_sel = step_qam256;
        top_sel  = 3'd7;
      end
    endcase
  end

  // threshold compares on both axes
  assign idx_i = level_index(i_sample, step_sel, top_sel);
  assign idx_q = level_index(q_sample, step_sel, top_sel);

  // sign decisions, strictly above zero
  assign pos_i = !i_sample[SAMPLE_W-1] && (i_sample != '0);
  assign pos_q = !q_sample[SAMPLE_W-1] && (q_sample != '0);

  // pack real code low, imaginary code above
  always_comb begin
    unique case (mode)
      MODE_BPSK: begin
        sym.valid = 1'b1;
        sym.nbits = NBITS_W'(1);
        sym.code  = CODE_W'(pos_i);
      end
      MODE_QPSK: begin
        sym.valid = 1'b1;
        sym.nbits = NBITS_W'(2);
        sym.code  = CODE_W'({pos_q, pos_i});
      end
      MODE_QAM16: begin
        sym.valid = 1'b1;
        sym.nbits = NBITS_W'(4);
        sym.code  = CODE_W'({gray16(idx_q[1:0]), gray16(idx_i[1:0])});
      end
      MODE_QAM64: begin
        sym.valid = 1'b1;
        sym.nbits = NBITS_W'(6);
        sym.code  = CODE_W'({gray64(idx_q[2:0]), gray64(idx_i[2:0])});
      end
      MODE_QAM256: begin
        sym.valid = 1'b1;
        sym.nbits = NBITS_W'(8);
        sym.code  = {gray256(idx_q), gray256(idx_i)};
      end
      default: begin
        sym.valid = 1'b0;
        sym.nbits = '0;
        sym.code  = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/qam_hard_demapper_unit.sv
// qam_hard_demapper_unit: top level of the hard-decision demapper, with input
// stage, bit packer and output register. Depends on qamhd_pkg, qamhd_slicer.
//
//   channel  ports                                   direction
//   in       in_valid, in_stall, in_i_sample/q       symbol requests in
//   out      out_valid, out_stall, out_byte          packed bytes out
//   cfg      cfg_we, cfg_addr, cfg_wdata             register writes in
//
// One symbol is taken per cycle while in_stall is low; a symbol is held in the input
// register from its accepting edge, and a byte it completes is then written to the output
// register once the output can take it (input register, then slicer and packer).
// The packer loop (pending bits and count) is closed through its own state registers.
// Synchronous active-low reset clears the stage valid flags and pending bits and loads the register reset values.
// A held output byte stalls the input only while the input register also
// holds a symbol.
`default_nettype none

module qam_hard_demapper_unit
  import qamhd_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // symbol input
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_i_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_q_sample,
  // byte output
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic        [7:0]          out_byte,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic        [ADDR_W-1:0]   cfg_addr,
  input  wire logic        [STEP_W-1:0]   cfg_wdata
);

  logic [MODE_W-1:0] mode_r;
  logic [STEP_W-1:0] step_qam16_r;
  logic [STEP_W-1:0] step_qam64_r;
  logic [STEP_W-1:0] step_qam256_r;

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_i_r;
  logic signed [SAMPLE_W-1:0] s1_q_r;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic [7:0]       out_byte_nxt;

  sym_code_t        sym;
  logic             adv;
  logic             accept_in;
  logic             fire;
  logic [ACC_W-1:0] merged;
  logic [CNT_W:0]   sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RST;
      step_qam16_r  <= STEP_QAM16_RST;
      step_qam64_r  <= STEP_QAM64_RST;
      step_qam256_r <= STEP_QAM256_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:        mode_r        <= cfg_wdata[MODE_W-1:0];
        CFG_STEP_QAM16:  step_qam16_r  <= cfg_wdata;
        CFG_STEP_QAM64:  step_qam64_r  <= cfg_wdata;
        CFG_STEP_QAM256: step_qam256_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: input stage moves whenever the output register can take a byte
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign accept_in = in_valid && !in_stall;

  assign s1_valid_nxt = accept_in || (s1_valid_r && !adv);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (accept_in) begin
      s1_i_r <= in_i_sample;
      s1_q_r <= in_q_sample;
    end
  end

  // slicing and gray mapping
  qamhd_slicer u_slicer (
    .i_sample    (s1_i_r),
    .q_sample    (s1_q_r),
    .mode        (mode_r),
    .step_qam16  (step_qam16_r),
    .step_qam64  (step_qam64_r),
    .step_qam256 (step_qam256_r),
    .sym         (sym)
  );

  // bit packer: append code after pending bits, emit a full byte
  assign fire   = s1_valid_r && adv && sym.valid;
  assign merged = acc_r | (ACC_W'(sym.code) << cnt_r);
  assign sum    = {1'b0, cnt_r} + sym.nbits;

  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      cnt_nxt = sum[CNT_W-1:0];
      if (sum[CNT_W]) begin
        out_byte_nxt  = merged[7:0];
        acc_nxt       = merged >> 8;
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt = merged;
      end
    end
  end

  // packer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

`ifndef SYNTHESIS
  // a new byte only comes from a symbol held in the input stage
  a_byte_from_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("byte appeared without a symbol in the input stage");

  // a stalled symbol stays in the input stage
  a_symbol_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("symbol dropped from the input stage");

  // an unused mode adds no bits
  a_unused_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && !sym.valid) |=> ($stable(cnt_r) && $stable(acc_r)))
    else $error("pending bits changed for an unused mode");

  // pending bits above the count are always clear
  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> cnt_r) == '0)
    else $error("stale bits above the pending count");
`endif

endmodule

`default_nettype wire
